// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMPERATURE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS_COEFF   = 3'd5;

  // Temperature thresholds in hundredths of a degree
  localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [18:0] TEMP_VLOW = -19'sd1500;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [18:0] temperature_centi;
    logic signed [31:0] pressure_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] offset_base;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] ref_temperature;
    logic [15:0] temp_sens_coeff;
  } cfg_regs_t;

  // First-order results handed to the correction stages
  typedef struct packed {
    logic signed [18:0] temp;
    logic [16:0]        t2;
    logic signed [34:0] off_lin;
    logic signed [34:0] sens_lin;
    logic [23:0]        d1;
  } front_t;

  // Corrected offset and sensitivity handed to the pressure stages
  typedef struct packed {
    logic signed [18:0] tc;
    logic signed [39:0] off;
    logic signed [39:0] sens;
    logic [23:0]        d1;
  } corr_t;

endpackage

// ===== hw/rtl/bpc_front.sv =====
module bpc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  bpc_pkg::in_item_t   up_data,
  input  bpc_pkg::cfg_regs_t  cfg,
  output logic                dn_valid,
  input  logic                dn_ready,
  output bpc_pkg::front_t     dn_data
);
  import bpc_pkg::*;

  logic [2:0] vld_r;
  logic [2:0] en;

  // Stage 1: temperature difference
  logic signed [24:0] dt_r, dt_nxt;
  logic [23:0]        d1_s1_r;

  // Stage 2: products against dt
  logic signed [40:0] tprod_r, tprod_nxt;
  logic signed [40:0] offp_r, offp_nxt;
  logic signed [40:0] sensp_r, sensp_nxt;
  logic signed [49:0] sq_full;
  logic [47:0]        sq_r, sq_nxt;
  logic [23:0]        d1_s2_r;

  // Stage 3: temperature and linear offset/sensitivity
  logic signed [40:0] tbias, offbias, sensbias;
  logic signed [40:0] tq, offq, sensq;
  logic signed [18:0] temp_r, temp_nxt;
  logic [16:0]        t2_r, t2_nxt;
  logic signed [34:0] offl_r, offl_nxt;
  logic signed [34:0] sensl_r, sensl_nxt;
  logic [23:0]        d1_s3_r;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[2] = ~vld_r[2] | dn_ready;
    en[1] = ~vld_r[1] | en[2];
    en[0] = ~vld_r[0] | en[1];
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // dt = D2 - C5 * 256
  always_comb begin
    dt_nxt = $signed({1'b0, up_data.raw_temperature})
           - $signed({1'b0, cfg.ref_temperature, 8'h00});
  end

  // Multiply dt by the temperature and pressure coefficients
  always_comb begin
    tprod_nxt = dt_r * $signed({1'b0, cfg.temp_sens_coeff});
    offp_nxt  = dt_r * $signed({1'b0, cfg.offset_temp_coeff});
    sensp_nxt = dt_r * $signed({1'b0, cfg.sens_temp_coeff});
    sq_full   = dt_r * dt_r;
    sq_nxt    = sq_full[47:0];
  end

  // Scale with truncation toward zero, add the base terms
  always_comb begin
    tbias    = tprod_r + (tprod_r[40] ? 41'sd8388607 : 41'sd0);
    offbias  = offp_r + (offp_r[40] ? 41'sd127 : 41'sd0);
    sensbias = sensp_r + (sensp_r[40] ? 41'sd255 : 41'sd0);
    tq       = tbias >>> 23;
    offq     = offbias >>> 7;
    sensq    = sensbias >>> 8;
    temp_nxt = $signed(tq[18:0]) + TEMP_REF;
    t2_nxt   = sq_r[47:31];
    offl_nxt  = $signed({3'b000, cfg.offset_base, 16'h0000}) + $signed(offq[34:0]);
    sensl_nxt = $signed({4'b0000, cfg.sens_base, 15'h0000}) + $signed(sensq[34:0]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt_r    <= dt_nxt;
      d1_s1_r <= up_data.raw_pressure;
    end
    if (en[1]) begin
      tprod_r <= tprod_nxt;
      offp_r  <= offp_nxt;
      sensp_r <= sensp_nxt;
      sq_r    <= sq_nxt;
      d1_s2_r <= d1_s1_r;
    end
    if (en[2]) begin
      temp_r  <= temp_nxt;
      t2_r    <= t2_nxt;
      offl_r  <= offl_nxt;
      sensl_r <= sensl_nxt;
      d1_s3_r <= d1_s2_r;
    end
  end

  always_comb begin
    dn_data.temp     = temp_r;
    dn_data.t2       = t2_r;
    dn_data.off_lin  = offl_r;
    dn_data.sens_lin = sensl_r;
    dn_data.d1       = d1_s3_r;
  end

`ifndef ASSERT_OFF
  // A stalled first stage keeps its dt
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && !en[0] |=> vld_r[0] && $stable(dt_r))
    else $error("stage 1 lost its item during a stall");
`endif

endmodule

// ===== hw/rtl/bpc_corr.sv =====
module bpc_corr (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  bpc_pkg::front_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output bpc_pkg::corr_t    dn_data
);
  import bpc_pkg::*;

  logic [2:0] vld_r;
  logic [2:0] en;

  // Stage 4: squares and thresholds
  logic signed [19:0] a_w, b_w, temp_w, tc_w;
  logic signed [39:0] a_sq, b_sq;
  logic [34:0]        a2_r, a2_nxt;
  logic [34:0]        b2_r, b2_nxt;
  logic               low_r, low_nxt;
  logic               vlow_r, vlow_nxt;
  logic signed [18:0] tc_s4_r, tc_nxt;
  logic signed [34:0] offl_s4_r, sensl_s4_r;
  logic [23:0]        d1_s4_r;

  // Stage 5: second-order terms
  logic [37:0]        a2w, b2w, a5, b7, b11;
  logic [37:0]        off2_r, off2_nxt;
  logic [37:0]        sens2_r, sens2_nxt;
  logic signed [18:0] tc_s5_r;
  logic signed [34:0] offl_s5_r, sensl_s5_r;
  logic [23:0]        d1_s5_r;

  // Stage 6: corrected offset and sensitivity
  logic signed [39:0] off_r, off_nxt;
  logic signed [39:0] sens_r, sens_nxt;
  logic signed [18:0] tc_s6_r;
  logic [23:0]        d1_s6_r;

  always_comb begin
    en[2] = ~vld_r[2] | dn_ready;
    en[1] = ~vld_r[1] | en[2];
    en[0] = ~vld_r[0] | en[1];
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // Square the distances from both thresholds; subtract T2 in the cold band only
  always_comb begin
    temp_w   = {up_data.temp[18], up_data.temp};
    a_w      = temp_w - 20'sd2000;
    b_w      = temp_w + 20'sd1500;
    a_sq     = a_w * a_w;
    b_sq     = b_w * b_w;
    a2_nxt   = a_sq[34:0];
    b2_nxt   = b_sq[34:0];
    low_nxt  = up_data.temp < TEMP_REF;
    vlow_nxt = up_data.temp < TEMP_VLOW;
    tc_w     = low_nxt ? temp_w - $signed({3'b000, up_data.t2}) : temp_w;
    tc_nxt   = tc_w[18:0];
  end

  // OFF2 = 5a^2/2 + 7b^2, SENS2 = 5a^2/4 + 11b^2/2, each part truncated
  always_comb begin
    a2w = 38'(a2_r);
    b2w = 38'(b2_r);
    a5  = a2w + (a2w << 2);
    b7  = (b2w << 3) - b2w;
    b11 = (b2w << 3) + (b2w << 1) + b2w;
    if (low_r) begin
      off2_nxt  = (a5 >> 1) + (vlow_r ? b7 : 38'd0);
      sens2_nxt = (a5 >> 2) + (vlow_r ? (b11 >> 1) : 38'd0);
    end else begin
      off2_nxt  = '0;
      sens2_nxt = '0;
    end
  end

  always_comb begin
    off_nxt  = {{5{offl_s5_r[34]}}, offl_s5_r} - {2'b00, off2_r};
    sens_nxt = {{5{sensl_s5_r[34]}}, sensl_s5_r} - {2'b00, sens2_r};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a2_r       <= a2_nxt;
      b2_r       <= b2_nxt;
      low_r      <= low_nxt;
      vlow_r     <= vlow_nxt;
      tc_s4_r    <= tc_nxt;
      offl_s4_r  <= up_data.off_lin;
      sensl_s4_r <= up_data.sens_lin;
      d1_s4_r    <= up_data.d1;
    end
    if (en[1]) begin
      off2_r     <= off2_nxt;
      sens2_r    <= sens2_nxt;
      tc_s5_r    <= tc_s4_r;
      offl_s5_r  <= offl_s4_r;
      sensl_s5_r <= sensl_s4_r;
      d1_s5_r    <= d1_s4_r;
    end
    if (en[2]) begin
      off_r   <= off_nxt;
      sens_r  <= sens_nxt;
      tc_s6_r <= tc_s5_r;
      d1_s6_r <= d1_s5_r;
    end
  end

  always_comb begin
    dn_data.tc   = tc_s6_r;
    dn_data.off  = off_r;
    dn_data.sens = sens_r;
    dn_data.d1   = d1_s6_r;
  end

`ifndef ASSERT_OFF
  // The very-low band lies inside the low band
  a_vlow_in_low: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && vlow_r |-> low_r)
    else $error("very-low flag set without low flag");

  // No second-order correction at or above the reference temperature
  a_warm_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && !low_r && en[1] |=> off2_r == '0 && sens2_r == '0)
    else $error("correction terms nonzero above reference temperature");
`endif

endmodule

// ===== hw/rtl/bpc_press.sv =====
module bpc_press (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  bpc_pkg::corr_t      up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output bpc_pkg::out_item_t  dn_data
);
  import bpc_pkg::*;

  logic [4:0] vld_r;
  logic [4:0] en;

  // Stage 7: partial products of D1 * SENS
  logic [43:0]        plo_r, plo_nxt;
  logic signed [44:0] phi_r, phi_nxt;
  logic signed [39:0] off_s7_r;
  logic signed [18:0] tc_s7_r;

  // Stage 8: full product
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [39:0] off_s8_r;
  logic signed [18:0] tc_s8_r;

  // Stage 9: product / 2^21
  logic signed [63:0] qbias;
  logic signed [42:0] q_r, q_nxt;
  logic signed [39:0] off_s9_r;
  logic signed [18:0] tc_s9_r;

  // Stage 10: subtract offset
  logic signed [43:0] r_r, r_nxt;
  logic signed [18:0] tc_s10_r;

  // Stage 11: result register
  logic signed [43:0] rbias;
  logic signed [28:0] p_w;
  out_item_t          res_r, res_nxt;

  always_comb begin
    en[4] = ~vld_r[4] | dn_ready;
    en[3] = ~vld_r[3] | en[4];
    en[2] = ~vld_r[2] | en[3];
    en[1] = ~vld_r[1] | en[2];
    en[0] = ~vld_r[0] | en[1];
  end

  assign up_ready = en[0];
  assign dn_valid = vld_r[4];
  assign dn_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= up_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
      if (en[4]) vld_r[4] <= vld_r[3];
    end
  end

  // Split SENS at bit 20 so each multiplier stays narrow
  always_comb begin
    plo_nxt = up_data.d1 * up_data.sens[19:0];
    phi_nxt = $signed({1'b0, up_data.d1}) * $signed(up_data.sens[39:20]);
  end

  always_comb begin
    prod_nxt = ({{19{phi_r[44]}}, phi_r} << 20) + {20'h00000, plo_r};
  end

  // Truncate toward zero by biasing negative values
  always_comb begin
    qbias = prod_r + (prod_r[63] ? 64'sd2097151 : 64'sd0);
    q_nxt = qbias[63:21];
  end

  always_comb begin
    r_nxt = {q_r[42], q_r} - {{4{off_s9_r[39]}}, off_s9_r};
  end

  // The quotient stays within 29 bits and is sign-extended to the 32-bit output
  always_comb begin
    rbias   = r_r + (r_r[43] ? 44'sd32767 : 44'sd0);
    p_w     = rbias[43:15];
    res_nxt.temperature_centi = tc_s10_r;
    res_nxt.pressure_out      = {{3{p_w[28]}}, p_w};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      plo_r    <= plo_nxt;
      phi_r    <= phi_nxt;
      off_s7_r <= up_data.off;
      tc_s7_r  <= up_data.tc;
    end
    if (en[1]) begin
      prod_r   <= prod_nxt;
      off_s8_r <= off_s7_r;
      tc_s8_r  <= tc_s7_r;
    end
    if (en[2]) begin
      q_r      <= q_nxt;
      off_s9_r <= off_s8_r;
      tc_s9_r  <= tc_s8_r;
    end
    if (en[3]) begin
      r_r      <= r_nxt;
      tc_s10_r <= tc_s9_r;
    end
    if (en[4]) begin
      res_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A stalled subtract stage keeps its value
  a_s10_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !en[3] |=> vld_r[3] && $stable(r_r))
    else $error("stage 10 lost its item during a stall");
`endif

endmodule

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// Channel  Ports                                     Direction  Payload
// in       in_valid, in_ready, in_data               sink       raw_pressure, raw_temperature
// out      out_valid, out_ready, out_data            source     temperature_centi, pressure_out
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data sink       one 16-bit calibration word
//
// Takes one sample pair per cycle through 11 register stages unless the output
// stalls; the split 24x40 pressure product is followed by two scaling steps.
// rst_n is synchronous: it empties the pipeline and clears the calibration words.
// Each stage holds only while its successor is full, so bubbles close up and
// input transfers continue while a result waits, until every stage is occupied.
module barometric_pressure_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bpc_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bpc_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);
  import bpc_pkg::*;

  cfg_regs_t cfg_r;

  logic   fr_valid, fr_ready;
  front_t fr_data;
  logic   co_valid, co_ready;
  corr_t  co_data;

  assign cfg_ready = 1'b1;

  // Write calibration words; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENS_BASE:         cfg_r.sens_base         <= cfg_data;
        REG_OFFSET_BASE:       cfg_r.offset_base       <= cfg_data;
        REG_SENS_TEMP_COEFF:   cfg_r.sens_temp_coeff   <= cfg_data;
        REG_OFFSET_TEMP_COEFF: cfg_r.offset_temp_coeff <= cfg_data;
        REG_REF_TEMPERATURE:   cfg_r.ref_temperature   <= cfg_data;
        REG_TEMP_SENS_COEFF:   cfg_r.temp_sens_coeff   <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .cfg      (cfg_r),
    .dn_valid (fr_valid),
    .dn_ready (fr_ready),
    .dn_data  (fr_data)
  );

  bpc_corr u_corr (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_data  (fr_data),
    .dn_valid (co_valid),
    .dn_ready (co_ready),
    .dn_data  (co_data)
  );

  bpc_press u_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (co_valid),
    .up_ready (co_ready),
    .up_data  (co_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule
